### design/iie_pkg.sv
`timescale 1ns / 1ps

package iie_pkg;

    localparam int DEF_NUM_REGS  = 256;
    localparam int DEF_MEM_BYTES = 65536;

    localparam logic [5:0] OP_NOP     = 6'd0;
    localparam logic [5:0] OP_ADD     = 6'd1;
    localparam logic [5:0] OP_SUB     = 6'd2;
    localparam logic [5:0] OP_MULT    = 6'd3;
    localparam logic [5:0] OP_DIV     = 6'd4;
    localparam logic [5:0] OP_ADDI    = 6'd5;
    localparam logic [5:0] OP_SUBI    = 6'd6;
    localparam logic [5:0] OP_RSUBI   = 6'd7;
    localparam logic [5:0] OP_MULTI   = 6'd8;
    localparam logic [5:0] OP_DIVI    = 6'd9;
    localparam logic [5:0] OP_RDIVI   = 6'd10;
    localparam logic [5:0] OP_AND     = 6'd11;
    localparam logic [5:0] OP_OR      = 6'd12;
    localparam logic [5:0] OP_XOR     = 6'd13;
    localparam logic [5:0] OP_ANDI    = 6'd14;
    localparam logic [5:0] OP_ORI     = 6'd15;
    localparam logic [5:0] OP_XORI    = 6'd16;
    localparam logic [5:0] OP_I2I     = 6'd17;
    localparam logic [5:0] OP_C2C     = 6'd18;
    localparam logic [5:0] OP_I2C     = 6'd19;
    localparam logic [5:0] OP_C2I     = 6'd20;
    localparam logic [5:0] OP_LOAD    = 6'd21;
    localparam logic [5:0] OP_LOADI   = 6'd22;
    localparam logic [5:0] OP_LOADAI  = 6'd23;
    localparam logic [5:0] OP_LOADAO  = 6'd24;
    localparam logic [5:0] OP_LSHIFT  = 6'd25;
    localparam logic [5:0] OP_LSHIFTI = 6'd26;
    localparam logic [5:0] OP_RSHIFT  = 6'd27;
    localparam logic [5:0] OP_RSHIFTI = 6'd28;
    localparam logic [5:0] OP_STOREAI = 6'd29;
    localparam logic [5:0] OP_STORE   = 6'd30;
    localparam logic [5:0] OP_STOREAO = 6'd31;
    localparam logic [5:0] OP_OUTAI   = 6'd32;
    localparam logic [5:0] OP_OUTPUT  = 6'd33;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_ADDR = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture request and start register reads
        logic fetch;      // read the third register on the second read port
        logic clr_step;   // write one register and one byte of the clearing pass
        logic decode;     // operands valid: compute, set up division or memory
        logic div_step;   // one quotient bit, or the final signed result
        logic mem_step;   // one step of a memory access: a byte written, or half of a byte read
        logic finish;     // drive the result and commit register write
    } iie_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_div;
        logic is_mem;
        logic div_done;
        logic mem_done;
    } iie_status_t;

endpackage

### design/iie_ctrl.sv
`timescale 1ns / 1ps

module iie_ctrl
    import iie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output iie_cmd_t    cmd,
    input  iie_status_t status
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_MEM   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.decode = 1'b1;
                if (status.is_div)
                    state_next = S_DIV;
                else if (status.is_mem)
                    state_next = S_MEM;
                else
                    state_next = S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = S_DONE;
            end
            S_MEM:
            begin
                cmd.mem_step = 1'b1;
                if (status.mem_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### design/iie_datapath.sv
`timescale 1ns / 1ps

module iie_datapath
    import iie_pkg::*;
#(
    parameter int NUM_REGS  = DEF_NUM_REGS,
    parameter int MEM_BYTES = DEF_MEM_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  iie_cmd_t           cmd,
    output iie_status_t        status,
    input  logic [5:0]         req_type,
    input  logic [7:0]         reg_one,
    input  logic [7:0]         reg_two,
    input  logic [7:0]         reg_three,
    input  logic signed [31:0] immediate,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic               reg_written,
    output logic               output_valid,
    output logic [1:0]         error_code
);

    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int AW = $clog2(MEM_BYTES);
    localparam int CW = (AW > RW) ? AW : RW;

    logic [31:0]   rf [NUM_REGS];
    logic [7:0]    mem [MEM_BYTES];

    logic [5:0]    op_reg;
    logic [RW-1:0] dst_reg;
    logic [31:0]   imm_reg;
    logic [31:0]   a_reg, b_reg, c_reg;
    logic [CW:0]   clr_cnt_reg;

    logic [31:0]   val_reg;
    logic          wr_reg, outv_reg;
    logic [1:0]    err_reg;
    logic [31:0]   pend_reg;      // store data, shifted out most significant byte first
    logic [AW-1:0] addr_reg;
    logic          mem_wr_reg;
    logic [1:0]    byte_cnt_reg;
    logic [7:0]    rd_byte_reg;
    logic          rd_phase_reg;
    logic          mem_active_reg;

    // division: restoring, one quotient bit per cycle
    logic [31:0]   dvd_reg, dvs_reg, rem_reg;
    logic [5:0]    div_cnt_reg;
    logic          div_neg_reg;

    logic [RW-1:0] clr_idx;
    logic [AW-1:0] clr_addr;
    logic [RW-1:0] rd2_idx;
    assign clr_idx  = clr_cnt_reg[RW-1:0];
    assign clr_addr = clr_cnt_reg[AW-1:0];
    // second read port: source two at capture, then the third register
    assign rd2_idx  = cmd.load ? reg_two[RW-1:0] : dst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_step && !status.clr_done)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end
    assign status.clr_done = (clr_cnt_reg >= (CW+1)'(MEM_BYTES - 1))
                          && (clr_cnt_reg >= (CW+1)'(NUM_REGS - 1));

    // register file, two read ports
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && (clr_cnt_reg < (CW+1)'(NUM_REGS)))
            rf[clr_idx] <= '0;
        else if (cmd.finish && wr_reg)
            rf[dst_reg] <= val_reg;
        if (cmd.load)
            a_reg <= rf[reg_one[RW-1:0]];
        if (cmd.load)
            b_reg <= rf[rd2_idx];
        else if (cmd.fetch)
            c_reg <= rf[rd2_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req_type;
            dst_reg <= reg_three[RW-1:0];
            imm_reg <= immediate;
        end
    end

    // memory, one byte per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && (clr_cnt_reg < (CW+1)'(MEM_BYTES)))
            mem[clr_addr] <= '0;
        else if (cmd.mem_step && mem_active_reg && mem_wr_reg)
            mem[addr_reg + AW'(byte_cnt_reg)] <= pend_reg[31:24];
        rd_byte_reg <= mem[addr_reg + AW'(byte_cnt_reg)];
    end

    // operation decode
    logic [31:0] opb, addr_c, alu;
    logic        is_div, is_mem, is_store, is_out, div0, alu_wr;
    logic [31:0] dvd_c, dvs_c;

    always_comb
    begin
        opb      = b_reg;
        alu      = '0;
        alu_wr   = 1'b0;
        is_div   = 1'b0;
        is_mem   = 1'b0;
        is_store = 1'b0;
        is_out   = 1'b0;
        div0     = 1'b0;
        addr_c   = '0;
        dvd_c    = a_reg;
        dvs_c    = b_reg;
        case (op_reg)
            OP_ADDI, OP_SUBI, OP_MULTI, OP_ANDI, OP_ORI, OP_XORI,
            OP_LSHIFTI, OP_RSHIFTI:
                opb = imm_reg;
            default:
                opb = b_reg;
        endcase
        unique case (op_reg)
            OP_ADD, OP_ADDI:       begin alu = a_reg + opb; alu_wr = 1'b1; end
            OP_SUB, OP_SUBI:       begin alu = a_reg - opb; alu_wr = 1'b1; end
            OP_RSUBI:              begin alu = imm_reg - a_reg; alu_wr = 1'b1; end
            OP_MULT, OP_MULTI:     begin alu = a_reg * opb; alu_wr = 1'b1; end
            OP_AND, OP_ANDI:       begin alu = a_reg & opb; alu_wr = 1'b1; end
            OP_OR, OP_ORI:         begin alu = a_reg | opb; alu_wr = 1'b1; end
            OP_XOR, OP_XORI:       begin alu = a_reg ^ opb; alu_wr = 1'b1; end
            OP_I2I:                begin alu = a_reg; alu_wr = 1'b1; end
            OP_C2C, OP_I2C, OP_C2I:
                                   begin alu = {24'd0, a_reg[7:0]}; alu_wr = 1'b1; end
            OP_LOADI:              begin alu = imm_reg; alu_wr = 1'b1; end
            OP_LSHIFT, OP_LSHIFTI: begin alu = a_reg << opb[4:0]; alu_wr = 1'b1; end
            OP_RSHIFT, OP_RSHIFTI:
                begin alu = $unsigned($signed(a_reg) >>> opb[4:0]); alu_wr = 1'b1; end
            OP_DIV:   begin is_div = 1'b1; div0 = (b_reg == '0); end
            OP_DIVI:  begin is_div = 1'b1; dvs_c = imm_reg; div0 = (imm_reg == '0); end
            OP_RDIVI: begin is_div = 1'b1; dvd_c = imm_reg; dvs_c = a_reg;
                            div0 = (a_reg == '0); end
            OP_LOAD:    begin is_mem = 1'b1; addr_c = a_reg; end
            OP_LOADAI:  begin is_mem = 1'b1; addr_c = a_reg + imm_reg; end
            OP_LOADAO:  begin is_mem = 1'b1; addr_c = a_reg + b_reg; end
            OP_STOREAI: begin is_mem = 1'b1; is_store = 1'b1; addr_c = b_reg + imm_reg; end
            OP_STORE:   begin is_mem = 1'b1; is_store = 1'b1; addr_c = b_reg; end
            OP_STOREAO: begin is_mem = 1'b1; is_store = 1'b1; addr_c = b_reg + c_reg; end
            OP_OUTAI:   begin is_mem = 1'b1; is_out = 1'b1; addr_c = a_reg + imm_reg; end
            OP_OUTPUT:  begin is_mem = 1'b1; is_out = 1'b1; addr_c = imm_reg; end
            default: ;
        endcase
    end

    logic addr_ok;
    assign addr_ok = {1'b0, addr_c} <= 33'(MEM_BYTES - 4);

    assign status.is_div = is_div && !div0;
    assign status.is_mem = is_mem && addr_ok;
    assign status.div_done = (div_cnt_reg == 6'd32);
    assign status.mem_done = rd_phase_reg && (byte_cnt_reg == 2'd3);

    logic [32:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_active_reg <= 1'b0;
            rd_phase_reg   <= 1'b0;
            byte_cnt_reg   <= '0;
            div_cnt_reg    <= '0;
        end
        else if (cmd.decode)
        begin
            mem_active_reg <= is_mem && addr_ok;
            rd_phase_reg   <= 1'b0;
            byte_cnt_reg   <= '0;
            div_cnt_reg    <= '0;
        end
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg + 1'b1;
        else if (cmd.mem_step)
        begin
            // reads take an address step and a data-return step for each byte
            if (mem_wr_reg)
            begin
                rd_phase_reg <= (byte_cnt_reg == 2'd2);
                byte_cnt_reg <= (byte_cnt_reg == 2'd3) ? byte_cnt_reg : byte_cnt_reg + 1'b1;
            end
            else if (!rd_phase_reg)
                rd_phase_reg <= 1'b1;
            else if (byte_cnt_reg != 2'd3)
            begin
                byte_cnt_reg <= byte_cnt_reg + 1'b1;
                rd_phase_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            val_reg    <= alu;
            wr_reg     <= alu_wr || (is_div && !div0) || (is_mem && addr_ok && !is_store
                          && !is_out);
            outv_reg   <= is_out && addr_ok;
            err_reg    <= (is_div && div0) ? ERR_DIV0 :
                          (is_mem && !addr_ok) ? ERR_ADDR : ERR_NONE;
            addr_reg   <= addr_c[AW-1:0];
            mem_wr_reg <= is_store;
            pend_reg   <= a_reg;
            dvd_reg    <= dvd_c[31] ? 32'd0 - dvd_c : dvd_c;
            dvs_reg    <= dvs_c[31] ? 32'd0 - dvs_c : dvs_c;
            div_neg_reg <= dvd_c[31] ^ dvs_c[31];
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_cnt_reg == 6'd32)
                val_reg <= div_neg_reg ? 32'd0 - dvd_reg : dvd_reg;
            else if (!rem_sub[32])
            begin
                rem_reg <= rem_sub[31:0];
                dvd_reg <= {dvd_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                dvd_reg <= {dvd_reg[30:0], 1'b0};
            end
        end
        else if (cmd.mem_step)
        begin
            if (mem_wr_reg)
                pend_reg <= {pend_reg[23:0], 8'd0};
            else if (rd_phase_reg)
                val_reg <= {val_reg[23:0], rd_byte_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_value <= (wr_reg || outv_reg) ? val_reg : 32'd0;
            reg_written  <= wr_reg;
            output_valid <= outv_reg;
            error_code   <= err_reg;
        end
    end

endmodule

### design/iloc_instruction_executor.sv
`timescale 1ns / 1ps

// Executes one ILOC instruction per start transfer. After reset the block
// clears its register file and byte memory, one entry per cycle, with busy
// high until both are cleared. Each instruction passes read, execute and done
// states; a division adds a state with one quotient bit per cycle, and a load,
// store or output adds one for the single-port byte memory, a byte at a time.
// The result is on the result ports with done high for one cycle, and stays
// there until the next result: the receiver cannot stall.
module iloc_instruction_executor
    import iie_pkg::*;
#(
    parameter int NUM_REGS  = DEF_NUM_REGS,
    parameter int MEM_BYTES = DEF_MEM_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [5:0]         req_type,
    input  logic [7:0]         reg_one,
    input  logic [7:0]         reg_two,
    input  logic [7:0]         reg_three,
    input  logic signed [31:0] immediate,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic               reg_written,
    output logic               output_valid,
    output logic [1:0]         error_code
);

    iie_cmd_t    cmd;
    iie_status_t status;

    iie_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    iie_datapath #(
        .NUM_REGS  (NUM_REGS),
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .reg_one      (reg_one),
        .reg_two      (reg_two),
        .reg_three    (reg_three),
        .immediate    (immediate),
        .done         (done),
        .result_value (result_value),
        .reg_written  (reg_written),
        .output_valid (output_valid),
        .error_code   (error_code)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb
    import iie_pkg::*;
();

    localparam int NREGS = DEF_NUM_REGS;
    localparam int MBYTES = DEF_MEM_BYTES;
    localparam int N_RANDOM = 1300;

    typedef struct packed {
        logic [5:0]  op;
        logic [7:0]  r1;
        logic [7:0]  r2;
        logic [7:0]  r3;
        logic [31:0] imm;
    } instr_t;

    typedef struct packed {
        logic [31:0] value;
        logic        wr;
        logic        outv;
        logic [1:0]  err;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [5:0] req_type;
    logic [7:0] reg_one;
    logic [7:0] reg_two;
    logic [7:0] reg_three;
    logic signed [31:0] immediate;
    logic done;
    logic signed [31:0] result_value;
    logic reg_written;
    logic output_valid;
    logic [1:0] error_code;

    iloc_instruction_executor DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .reg_one(reg_one), .reg_two(reg_two),
        .reg_three(reg_three), .immediate(immediate), .done(done),
        .result_value(result_value), .reg_written(reg_written),
        .output_valid(output_valid), .error_code(error_code)
    );

    logic [31:0] shadow_regs [NREGS];
    logic [7:0]  shadow_mem [MBYTES];

    instr_t   pending_instrs [$];
    outcome_t expected_outcomes [$];
    int       mismatches = 0;
    int       gap_left = 0;
    bit       quiet_tail = 0;
    bit       hold_for_drain = 0;
    bit       stim_done = 0;
    bit       took = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] quot32(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic bit in_range(logic [31:0] a);
        return {32'd0, a} + 64'd4 <= 64'(MBYTES);
    endfunction

    function automatic logic [31:0] mem_word(logic [31:0] a);
        return {shadow_mem[a], shadow_mem[a + 1], shadow_mem[a + 2], shadow_mem[a + 3]};
    endfunction

    function automatic outcome_t execute_instr(instr_t t);
        outcome_t o;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] addr;
        bit mem_rd;
        bit do_store;
        a = shadow_regs[t.r1];
        b = shadow_regs[t.r2];
        c = shadow_regs[t.r3];
        o = '0;
        addr = '0;
        mem_rd = 0;
        do_store = 0;
        o.wr = 1'b1;
        case (t.op)
            OP_ADD:     o.value = a + b;
            OP_SUB:     o.value = a - b;
            OP_MULT:    o.value = a * b;
            OP_DIV:     if (b == 0) o.err = ERR_DIV0; else o.value = quot32(a, b);
            OP_ADDI:    o.value = a + t.imm;
            OP_SUBI:    o.value = a - t.imm;
            OP_RSUBI:   o.value = t.imm - a;
            OP_MULTI:   o.value = a * t.imm;
            OP_DIVI:    if (t.imm == 0) o.err = ERR_DIV0; else o.value = quot32(a, t.imm);
            OP_RDIVI:   if (a == 0) o.err = ERR_DIV0; else o.value = quot32(t.imm, a);
            OP_AND:     o.value = a & b;
            OP_OR:      o.value = a | b;
            OP_XOR:     o.value = a ^ b;
            OP_ANDI:    o.value = a & t.imm;
            OP_ORI:     o.value = a | t.imm;
            OP_XORI:    o.value = a ^ t.imm;
            OP_I2I:     o.value = a;
            OP_C2C, OP_I2C, OP_C2I: o.value = a & 32'hFF;
            OP_LOAD:    begin addr = a; mem_rd = 1; end
            OP_LOADI:   o.value = t.imm;
            OP_LOADAI:  begin addr = a + t.imm; mem_rd = 1; end
            OP_LOADAO:  begin addr = a + b; mem_rd = 1; end
            OP_LSHIFT:  o.value = a << b[4:0];
            OP_LSHIFTI: o.value = a << t.imm[4:0];
            OP_RSHIFT:  o.value = $signed(a) >>> b[4:0];
            OP_RSHIFTI: o.value = $signed(a) >>> t.imm[4:0];
            OP_STOREAI: begin addr = b + t.imm; do_store = 1; end
            OP_STORE:   begin addr = b; do_store = 1; end
            OP_STOREAO: begin addr = b + c; do_store = 1; end
            OP_OUTAI, OP_OUTPUT:
            begin
                addr = (t.op == OP_OUTAI) ? a + t.imm : t.imm;
                o.wr = 1'b0;
                if (in_range(addr))
                begin
                    o.value = mem_word(addr);
                    o.outv = 1'b1;
                end
                else
                    o.err = ERR_ADDR;
            end
            default:    o.wr = 1'b0;
        endcase
        if (o.err == ERR_DIV0)
            o.wr = 1'b0;
        if (do_store)
        begin
            o.wr = 1'b0;
            if (in_range(addr))
                {shadow_mem[addr], shadow_mem[addr + 1], shadow_mem[addr + 2],
                 shadow_mem[addr + 3]} = a;
            else
                o.err = ERR_ADDR;
        end
        if (mem_rd)
        begin
            if (in_range(addr))
                o.value = mem_word(addr);
            else
            begin
                o.wr = 1'b0;
                o.err = ERR_ADDR;
            end
        end
        if (o.wr)
            shadow_regs[t.r3] = o.value;
        return o;
    endfunction

    // transfer taken at the rising edge when start is high and busy is low
    always @(posedge clk)
        took <= rst_n && start && !busy;

    // driver: falling edge updates
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took)
            begin
                expected_outcomes.push_back(execute_instr(pending_instrs.pop_front()));
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (hold_for_drain && expected_outcomes.size() != 0)
                start <= 1'b0;
            else if (pending_instrs.size() != 0 && !(took && !quiet_tail
                     && $urandom_range(0, 15) == 0))
            begin
                hold_for_drain <= 1'b0;
                start <= 1'b1;
                req_type <= pending_instrs[0].op;
                reg_one <= pending_instrs[0].r1;
                reg_two <= pending_instrs[0].r2;
                reg_three <= pending_instrs[0].r3;
                immediate <= pending_instrs[0].imm;
            end
            else
            begin
                start <= 1'b0;
                if (!quiet_tail && pending_instrs.size() != 0)
                    gap_left <= $urandom_range(1, 17);
            end
        end
    end

    // note: the driver peeks pending_instrs[0] only after popping the accepted one
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h", result_value);
            end
            else
            begin
                outcome_t e;
                e = expected_outcomes.pop_front();
                if (e.value !== result_value || e.wr !== reg_written
                    || e.outv !== output_valid || e.err !== error_code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp val=%h wr=%b out=%b err=%0d",
                                 e.value, e.wr, e.outv, e.err,
                                 " got val=%h wr=%b out=%b err=%0d",
                                 result_value, reg_written, output_valid, error_code);
                end
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 6))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return 32'h80000000;
            3: return 32'h7FFFFFFF;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return MBYTES - 4 + $urandom_range(0, 5);
            1: return $urandom;
            2: return -$urandom_range(1, 8);
            default: return $urandom_range(0, 63) * 4 + $urandom_range(0, 3);
        endcase
    endfunction

    function automatic instr_t make(logic [5:0] op, logic [7:0] r1, logic [7:0] r2,
                                    logic [7:0] r3, logic [31:0] imm);
        instr_t t;
        t.op = op; t.r1 = r1; t.r2 = r2; t.r3 = r3; t.imm = imm;
        return t;
    endfunction

    // small register pool so values chain through results; addresses live in regs 0..3
    function automatic instr_t random_instr();
        logic [5:0] op;
        logic [7:0] r1;
        logic [7:0] r2;
        logic [7:0] r3;
        logic [31:0] imm;
        if ($urandom_range(0, 19) == 0)
            op = 6'($urandom_range(34, 63));
        else
            op = 6'($urandom_range(0, 33));
        r1 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        r2 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        r3 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(4, 15));
        imm = pick_value();
        case (op)
            OP_LOAD, OP_LOADAO, OP_STORE, OP_STOREAO:
            begin
                r1 = 8'($urandom_range(4, 15));
                r2 = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 1)) r3 = 8'($urandom_range(0, 3));
            end
            OP_LOADAI, OP_OUTAI, OP_STOREAI:
            begin
                r1 = 8'($urandom_range(0, 3));
                r2 = 8'($urandom_range(0, 3));
                imm = $urandom_range(0, 1) ? $urandom_range(0, 64) : pick_addr();
            end
            OP_OUTPUT: imm = pick_addr();
            OP_DIV, OP_DIVI, OP_RDIVI:
                if ($urandom_range(0, 3) == 0) imm = 0;
            default: ;
        endcase
        if (op == OP_LOADI && r3 < 4)
            imm = pick_addr();
        return make(op, r1, r2, r3, imm);
    endfunction

    initial
    begin
        start = 1'b0;
        req_type = '0;
        reg_one = '0;
        reg_two = '0;
        reg_three = '0;
        immediate = '0;
        rst_n = 1'b0;
        for (int i = 0; i < NREGS; i++)
            shadow_regs[i] = '0;
        for (int i = 0; i < MBYTES; i++)
            shadow_mem[i] = '0;

        // directed: extremes, every operation, errors and wrap cases
        pending_instrs.push_back(make(OP_LOADI, 8'd0, 8'd0, 8'd1, 32'h80000000));
        pending_instrs.push_back(make(OP_LOADI, 8'd0, 8'd0, 8'd2, 32'hFFFFFFFF));
        pending_instrs.push_back(make(OP_DIV, 8'd1, 8'd2, 8'd5, 32'd0));
        pending_instrs.push_back(make(OP_DIV, 8'd1, 8'd0, 8'd5, 32'd0));
        pending_instrs.push_back(make(OP_DIVI, 8'd1, 8'd0, 8'd6, 32'd0));
        pending_instrs.push_back(make(OP_RDIVI, 8'd0, 8'd0, 8'd6, 32'd7));
        pending_instrs.push_back(make(OP_RDIVI, 8'd2, 8'd0, 8'd6, 32'h80000001));
        pending_instrs.push_back(make(OP_LOADI, 8'd0, 8'd0, 8'd255, 32'h7FFFFFFF));
        for (int op = 1; op <= 33; op++)
            pending_instrs.push_back(make(6'(op), 8'd255, 8'd1, 8'd7, 32'hFFFFFFE1));
        pending_instrs.push_back(make(OP_LOADI, 8'd0, 8'd0, 8'd3, MBYTES - 4));
        pending_instrs.push_back(make(OP_STORE, 8'd1, 8'd3, 8'd0, 32'd0));
        pending_instrs.push_back(make(OP_OUTPUT, 8'd0, 8'd0, 8'd0, MBYTES - 4));
        pending_instrs.push_back(make(OP_OUTPUT, 8'd0, 8'd0, 8'd0, MBYTES - 3));
        pending_instrs.push_back(make(OP_STOREAI, 8'd2, 8'd3, 8'd0, 32'd1));
        pending_instrs.push_back(make(OP_STOREAO, 8'd2, 8'd3, 8'd2, 32'd0));
        pending_instrs.push_back(make(6'd63, 8'd255, 8'd255, 8'd255, 32'hFFFFFFFF));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_instrs.size() == 0);
        hold_for_drain = 1'b1;
        wait (expected_outcomes.size() == 0);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                wait (pending_instrs.size() == 0);
                hold_for_drain = 1'b1;
            end
            pending_instrs.push_back(random_instr());
        end
        wait (pending_instrs.size() <= 150);
        quiet_tail = 1'b1;
        wait (pending_instrs.size() == 0);
        wait (expected_outcomes.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
design/iie_pkg.sv
design/iie_ctrl.sv
design/iie_datapath.sv
design/iloc_instruction_executor.sv
verif/tb.sv
